// ----- rtl/core/vfa_pkg.sv -----
// Package: widths, opcodes, shared types and the saturation function of the vector ALU.
`default_nettype none
package vfa_pkg;

  localparam int W_BITS    = 32;
  localparam int F_BITS    = 16;
  localparam int N_BITS    = W_BITS + F_BITS;
  localparam int P_BITS    = 2 * W_BITS;
  localparam int RAD_BITS  = 2 * W_BITS;
  localparam int EXT_BITS  = 2 * W_BITS + 3;
  localparam int REM_BITS  = W_BITS + 3;
  localparam int SQ_STAGES = W_BITS;
  localparam int DV_STAGES = N_BITS;

  typedef enum logic [3:0] {
    OP_ADDV  = 4'd0,
    OP_ADDS  = 4'd1,
    OP_SUBV  = 4'd2,
    OP_SUBS  = 4'd3,
    OP_DOT   = 4'd4,
    OP_SCALE = 4'd5,
    OP_DIV   = 4'd6,
    OP_CROSS = 4'd7,
    OP_LEN   = 4'd8,
    OP_NORM  = 4'd9
  } op_t;

  typedef struct packed {
    logic              clip;
    logic [W_BITS-1:0] val;
  } sat_t;

  typedef struct packed {
    op_t               op;
    logic [W_BITS-1:0] rx;
    logic [W_BITS-1:0] ry;
    logic [W_BITS-1:0] rz;
    logic [W_BITS-1:0] sc;
    logic              clip;
    logic              bad;
    logic [W_BITS-1:0] amag0;
    logic [W_BITS-1:0] amag1;
    logic [W_BITS-1:0] amag2;
    logic [2:0]        aneg;
    logic              bneg;
    logic [W_BITS-1:0] bmag;
    logic [W_BITS-1:0] len;
  } side_t;

  function automatic sat_t sat_word(input logic signed [EXT_BITS-1:0] v);
    sat_t r;
    if (v[EXT_BITS-1:W_BITS-1] == '0 || v[EXT_BITS-1:W_BITS-1] == '1) begin
      r.clip = 1'b0;
      r.val  = v[W_BITS-1:0];
    end else begin
      r.clip = 1'b1;
      r.val  = v[EXT_BITS-1] ? {1'b1, {(W_BITS-1){1'b0}}} : {1'b0, {(W_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/vfa_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module vfa_sqrt import vfa_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [RAD_BITS-1:0] rad,
  output logic [W_BITS-1:0]   root
);

  logic [REM_BITS-1:0] rem_r  [SQ_STAGES];
  logic [W_BITS-1:0]   root_r [SQ_STAGES];
  logic [RAD_BITS-1:0] rad_r  [SQ_STAGES];

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
    logic [REM_BITS-1:0] rem_in, curr, trial;
    logic [W_BITS-1:0]   root_in;
    logic [RAD_BITS-1:0] rad_in;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end
    assign curr  = {rem_in[REM_BITS-3:0], rad_in[RAD_BITS-1 -: 2]};
    assign trial = REM_BITS'({root_in, 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        if (curr >= trial) begin
          rem_r[i]  <= curr - trial;
          root_r[i] <= {root_in[W_BITS-2:0], 1'b1};
        end else begin
          rem_r[i]  <= curr;
          root_r[i] <= {root_in[W_BITS-2:0], 1'b0};
        end
        rad_r[i] <= rad_in << 2;
      end
    end
  end

  assign root = root_r[SQ_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/core/vfa_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module vfa_div import vfa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [N_BITS-1:0] num,
  input  logic [W_BITS-1:0] den,
  output logic [N_BITS-1:0] quo
);

  logic [W_BITS-1:0] rem_r [DV_STAGES];
  logic [N_BITS-1:0] num_r [DV_STAGES];
  logic [W_BITS-1:0] den_r [DV_STAGES];

  for (genvar i = 0; i < DV_STAGES; i++) begin : g_stage
    logic [W_BITS-1:0] rem_in, den_in;
    logic [N_BITS-1:0] num_in;
    logic [W_BITS:0]   curr, diff;
    logic              ge;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
    end
    assign curr = {rem_in, num_in[N_BITS-1]};
    assign ge   = curr >= {1'b0, den_in};
    assign diff = curr - {1'b0, den_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[W_BITS-1:0] : curr[W_BITS-1:0];
        num_r[i] <= {num_in[N_BITS-2:0], ge};
        den_r[i] <= den_in;
      end
    end
  end

  assign quo = num_r[DV_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/core/vec3_fixed_point_alu.sv -----
// Top level: pipelined three-component Q16.16 vector ALU.
//
// Input channel in_valid/in_ready carries one word: opcode and vectors A, B.
// Result channel out_valid/out_ready carries one word per input word:
// rx, ry, rz, scalar_out and the saturated / bad_divisor flags.
// Every word passes the same pipeline: input register, multiplier stage,
// combine stage, a 32-stage square root, a 48-stage divider and the output
// register, whatever its opcode.
// Throughput is one word per clock; the pipeline advances whenever the
// output register is empty or being taken, so in_ready follows out_ready.
// When the receiver stalls, the whole pipeline holds, nothing is dropped.
// Reset clears all valid bits; payload registers are not reset.
// Divide by zero or normalize of a zero vector returns zeros with
// bad_divisor set.
`default_nettype none
module vec3_fixed_point_alu import vfa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3:0]               in_opcode,
  input  logic signed [W_BITS-1:0] in_ax,
  input  logic signed [W_BITS-1:0] in_ay,
  input  logic signed [W_BITS-1:0] in_az,
  input  logic signed [W_BITS-1:0] in_bx,
  input  logic signed [W_BITS-1:0] in_by,
  input  logic signed [W_BITS-1:0] in_bz,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [W_BITS-1:0] out_rx,
  output logic signed [W_BITS-1:0] out_ry,
  output logic signed [W_BITS-1:0] out_rz,
  output logic signed [W_BITS-1:0] out_scalar_out,
  output logic                     out_saturated,
  output logic                     out_bad_divisor
);

  logic en;
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic [SQ_STAGES-1:0] vq_r;
  logic [DV_STAGES-1:0] vd_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: input register
  op_t                     s1_op_r;
  logic signed [W_BITS-1:0] s1_a_r [3];
  logic signed [W_BITS-1:0] s1_b_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r   <= op_t'(in_opcode);
      s1_a_r[0] <= in_ax;
      s1_a_r[1] <= in_ay;
      s1_a_r[2] <= in_az;
      s1_b_r[0] <= in_bx;
      s1_b_r[1] <= in_by;
      s1_b_r[2] <= in_bz;
    end
  end

  // stage 2: products
  logic signed [W_BITS-1:0] ma [6];
  logic signed [W_BITS-1:0] mb [6];
  op_t                      s2_op_r;
  logic signed [W_BITS-1:0] s2_a_r [3];
  logic signed [W_BITS-1:0] s2_b_r [3];
  logic signed [P_BITS-1:0] s2_p_r [6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ma[k]   = s1_a_r[k];
      mb[k]   = s1_b_r[k];
      ma[k+3] = '0;
      mb[k+3] = '0;
    end
    unique case (s1_op_r)
      OP_SCALE: begin
        for (int k = 0; k < 3; k++) mb[k] = s1_b_r[0];
      end
      OP_CROSS: begin
        ma[0] = s1_a_r[1]; mb[0] = s1_b_r[2];
        ma[1] = s1_a_r[2]; mb[1] = s1_b_r[1];
        ma[2] = s1_a_r[2]; mb[2] = s1_b_r[0];
        ma[3] = s1_a_r[0]; mb[3] = s1_b_r[2];
        ma[4] = s1_a_r[0]; mb[4] = s1_b_r[1];
        ma[5] = s1_a_r[1]; mb[5] = s1_b_r[0];
      end
      OP_LEN, OP_NORM: begin
        for (int k = 0; k < 3; k++) mb[k] = s1_a_r[k];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op_r <= s1_op_r;
      for (int k = 0; k < 3; k++) begin
        s2_a_r[k] <= s1_a_r[k];
        s2_b_r[k] <= s1_b_r[k];
      end
      for (int k = 0; k < 6; k++) s2_p_r[k] <= ma[k] * mb[k];
    end
  end

  // stage 3: sums, shifts and saturation of the direct results
  logic signed [EXT_BITS-1:0] ea [3];
  logic signed [EXT_BITS-1:0] eb [3];
  logic signed [EXT_BITS-1:0] ep [6];
  logic signed [EXT_BITS-1:0] sum3;
  sat_t                       s3_res [3];
  sat_t                       s3_sc;
  side_t                      s3_side;
  side_t                      s3_side_r;
  logic [RAD_BITS-1:0]        s3_rad_r;
  logic [W_BITS-1:0]          amag [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ea[k]   = EXT_BITS'(s2_a_r[k]);
      eb[k]   = EXT_BITS'(s2_b_r[k]);
      amag[k] = s2_a_r[k][W_BITS-1] ? W_BITS'(-s2_a_r[k]) : s2_a_r[k];
      s3_res[k] = '0;
    end
    for (int k = 0; k < 6; k++) ep[k] = EXT_BITS'(s2_p_r[k]);
    sum3  = ep[0] + ep[1] + ep[2];
    s3_sc = '0;
    unique case (s2_op_r)
      OP_ADDV:  for (int k = 0; k < 3; k++) s3_res[k] = sat_word(ea[k] + eb[k]);
      OP_ADDS:  for (int k = 0; k < 3; k++) s3_res[k] = sat_word(ea[k] + eb[0]);
      OP_SUBV:  for (int k = 0; k < 3; k++) s3_res[k] = sat_word(ea[k] - eb[k]);
      OP_SUBS:  for (int k = 0; k < 3; k++) s3_res[k] = sat_word(ea[k] - eb[0]);
      OP_DOT:   s3_sc = sat_word(sum3 >>> F_BITS);
      OP_SCALE: for (int k = 0; k < 3; k++) s3_res[k] = sat_word(ep[k] >>> F_BITS);
      OP_CROSS: begin
        s3_res[0] = sat_word((ep[0] - ep[1]) >>> F_BITS);
        s3_res[1] = sat_word((ep[2] - ep[3]) >>> F_BITS);
        s3_res[2] = sat_word((ep[4] - ep[5]) >>> F_BITS);
      end
      default: ;
    endcase
    s3_side.op    = s2_op_r;
    s3_side.rx    = s3_res[0].val;
    s3_side.ry    = s3_res[1].val;
    s3_side.rz    = s3_res[2].val;
    s3_side.sc    = s3_sc.val;
    s3_side.clip  = s3_res[0].clip | s3_res[1].clip | s3_res[2].clip | s3_sc.clip;
    s3_side.bad   = (s2_op_r == OP_DIV && s2_b_r[0] == '0) ||
                    (s2_op_r == OP_NORM && s2_a_r[0] == '0 && s2_a_r[1] == '0 &&
                     s2_a_r[2] == '0);
    s3_side.amag0 = amag[0];
    s3_side.amag1 = amag[1];
    s3_side.amag2 = amag[2];
    s3_side.aneg  = {s2_a_r[2][W_BITS-1], s2_a_r[1][W_BITS-1], s2_a_r[0][W_BITS-1]};
    s3_side.bneg  = s2_b_r[0][W_BITS-1];
    s3_side.bmag  = s2_b_r[0][W_BITS-1] ? W_BITS'(-s2_b_r[0]) : s2_b_r[0];
    s3_side.len   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s3_side;
      s3_rad_r  <= sum3[RAD_BITS-1:0];
    end
  end

  // square root stages
  logic [W_BITS-1:0] root;
  side_t             sq_side_r [SQ_STAGES];

  vfa_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s3_rad_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= s3_side_r;
      for (int k = 1; k < SQ_STAGES; k++) sq_side_r[k] <= sq_side_r[k-1];
    end
  end

  // divider stages
  side_t             dv_in;
  logic [W_BITS-1:0] den;
  logic [N_BITS-1:0] num [3];
  logic [N_BITS-1:0] quo [3];
  side_t             dv_side_r [DV_STAGES];

  always_comb begin
    dv_in     = sq_side_r[SQ_STAGES-1];
    dv_in.len = root;
    den       = (dv_in.op == OP_DIV) ? dv_in.bmag : root;
    num[0]    = {dv_in.amag0, {F_BITS{1'b0}}};
    num[1]    = {dv_in.amag1, {F_BITS{1'b0}}};
    num[2]    = {dv_in.amag2, {F_BITS{1'b0}}};
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    vfa_div u_div (
      .clk (clk),
      .en  (en),
      .num (num[g]),
      .den (den),
      .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= dv_in;
      for (int k = 1; k < DV_STAGES; k++) dv_side_r[k] <= dv_side_r[k-1];
    end
  end

  // output stage
  side_t                      fin;
  logic signed [EXT_BITS-1:0] qe [3];
  sat_t                       qs [3];
  sat_t                       ls;
  logic [W_BITS-1:0]          rx_nxt, ry_nxt, rz_nxt, sc_nxt;
  logic                       sat_nxt;
  logic                       neg;

  always_comb begin
    fin = dv_side_r[DV_STAGES-1];
    for (int k = 0; k < 3; k++) begin
      neg   = fin.aneg[k] ^ (fin.op == OP_DIV && fin.bneg);
      qe[k] = neg ? -$signed(EXT_BITS'(quo[k])) : $signed(EXT_BITS'(quo[k]));
      qs[k] = sat_word(qe[k]);
    end
    ls      = sat_word($signed(EXT_BITS'(fin.len)));
    rx_nxt  = fin.rx;
    ry_nxt  = fin.ry;
    rz_nxt  = fin.rz;
    sc_nxt  = fin.sc;
    sat_nxt = fin.clip;
    if ((fin.op == OP_DIV || fin.op == OP_NORM) && !fin.bad) begin
      rx_nxt  = qs[0].val;
      ry_nxt  = qs[1].val;
      rz_nxt  = qs[2].val;
      sat_nxt = qs[0].clip | qs[1].clip | qs[2].clip;
    end else if (fin.op == OP_LEN) begin
      sc_nxt  = ls.val;
      sat_nxt = ls.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rx          <= rx_nxt;
      out_ry          <= ry_nxt;
      out_rz          <= rz_nxt;
      out_scalar_out  <= sc_nxt;
      out_saturated   <= sat_nxt;
      out_bad_divisor <= fin.bad;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      vq_r        <= '0;
      vd_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      vq_r        <= {vq_r[SQ_STAGES-2:0], v3_r};
      vd_r        <= {vd_r[DV_STAGES-2:0], vq_r[SQ_STAGES-1]};
      out_valid_r <= vd_r[DV_STAGES-1];
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- rtl/core/vfa_checker.sv -----
// Port-level checker for the vector ALU, bound to the top level.
`default_nettype none
module vfa_checker import vfa_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [W_BITS-1:0] out_rx,
  input logic signed [W_BITS-1:0] out_ry,
  input logic signed [W_BITS-1:0] out_rz,
  input logic                     out_saturated,
  input logic                     out_bad_divisor
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rx))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stage");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_divisor |-> out_rx == '0 && out_ry == '0 && out_rz == '0)
    else $error("bad divisor with nonzero vector");

  a_bad_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_divisor |-> !out_saturated)
    else $error("bad divisor with saturated flag");

endmodule

bind vec3_fixed_point_alu vfa_checker u_vfa_checker (.*);
`default_nettype wire
